// ===== rtl/sfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the sensor frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 999;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int PAYLOAD_CNT_W = 10;
    localparam int READING_CNT_W = 3;
    localparam int READING_NUM   = 7;
    localparam int HEADER_BYTES  = 6;

    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_READING = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_READING = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Command from the front end to the byte sequencer.
    // header : d0 destination, d1 sender, d2 origin node, flags
    // reading: d0 low byte, d1 high byte
    // payload: d0 data byte, emit = byte is passed, close = append checksum
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       text;
        logic       info;
        logic       keep;
        logic       emit;
        logic       close;
    } cmd_t;

endpackage

// ===== rtl/sfb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_front
// Accepts input words, tracks the frame phase and queues byte commands.
// ----------------------------------------------------------------------------
module sfb_front #(
    parameter int MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          operation,
    input  logic [7:0]          destination,
    input  logic [7:0]          sender,
    input  logic [7:0]          origin_node,
    input  logic                text_flag,
    input  logic                info_flag,
    input  logic                keepalive_flag,
    input  logic [15:0]         reading,
    input  logic [7:0]          data_byte,
    input  logic                payload_last,
    output logic                push,
    output sfb_pkg::cmd_t       cmd
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_READINGS = 2'd1;
    localparam logic [1:0] PH_PAYLOAD  = 2'd2;

    localparam logic [sfb_pkg::PAYLOAD_CNT_W-1:0] PAYLOAD_LIMIT =
        sfb_pkg::PAYLOAD_CNT_W'(MAX_PAYLOAD);
    localparam logic [sfb_pkg::READING_CNT_W-1:0] READING_FINAL =
        sfb_pkg::READING_CNT_W'(sfb_pkg::READING_NUM - 1);

    logic [1:0]                        phase_reg, phase_next;
    logic [sfb_pkg::READING_CNT_W-1:0] reading_count_reg, reading_count_next;
    logic [sfb_pkg::PAYLOAD_CNT_W-1:0] payload_count_reg, payload_count_next;
    logic                              room;

    always_comb
    begin
        phase_next         = phase_reg;
        reading_count_next = reading_count_reg;
        payload_count_next = payload_count_reg;
        push               = 1'b0;
        room               = payload_count_reg < PAYLOAD_LIMIT;

        cmd.kind  = sfb_pkg::KIND_PAYLOAD;
        cmd.d0    = data_byte;
        cmd.d1    = destination;
        cmd.d2    = origin_node;
        cmd.text  = text_flag;
        cmd.info  = info_flag;
        cmd.keep  = keepalive_flag;
        cmd.emit  = room;
        cmd.close = payload_last;

        if (accept)
        begin
            unique case (operation)
                sfb_pkg::OP_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push               = 1'b1;
                        cmd.kind           = sfb_pkg::KIND_HEADER;
                        cmd.d0             = destination;
                        cmd.d1             = sender;
                        reading_count_next = '0;
                        payload_count_next = '0;
                        phase_next         = text_flag ? PH_PAYLOAD : PH_READINGS;
                    end
                end
                sfb_pkg::OP_READING:
                begin
                    if (phase_reg == PH_READINGS)
                    begin
                        push               = 1'b1;
                        cmd.kind           = sfb_pkg::KIND_READING;
                        cmd.d0             = reading[7:0];
                        cmd.d1             = reading[15:8];
                        reading_count_next = reading_count_reg + 1'b1;
                        if (reading_count_reg == READING_FINAL)
                            phase_next = PH_PAYLOAD;
                    end
                end
                sfb_pkg::OP_PAYLOAD:
                begin
                    if (phase_reg == PH_PAYLOAD)
                    begin
                        push = room || payload_last;
                        if (room)
                            payload_count_next = payload_count_reg + 1'b1;
                        if (payload_last)
                            phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            reading_count_reg <= '0;
            payload_count_reg <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            reading_count_reg <= reading_count_next;
            payload_count_reg <= payload_count_next;
        end
    end

endmodule

// ===== rtl/sfb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_fifo
// Small command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module sfb_fifo #(
    parameter int DEPTH = sfb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfb_pkg::cmd_t push_data,
    input  logic          pop,
    output sfb_pkg::cmd_t pop_data,
    output logic          empty,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfb_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sfb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_back
// Byte sequencer: expands queued commands into frame bytes, keeps the
// running sum and holds the output word register.
// ----------------------------------------------------------------------------
module sfb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sfb_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    frame_byte,
    output logic          frame_last
);

    localparam logic [2:0] HEADER_LAST = 3'(sfb_pkg::HEADER_BYTES - 1);

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [2:0]  step;
    logic [2:0]  last_step;
    logic [7:0]  sel_byte;
    logic        sel_last;
    logic        summed;
    logic        load;

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

    always_comb
    begin
        step      = idx_reg;
        last_step = 3'd0;
        sel_byte  = cmd.d0;
        sel_last  = 1'b0;
        summed    = 1'b1;

        unique case (cmd.kind)
            sfb_pkg::KIND_HEADER:
            begin
                last_step = HEADER_LAST;
                case (step)
                    3'd0:    sel_byte = cmd.d0;
                    3'd1:    sel_byte = cmd.d1;
                    3'd2:    sel_byte = {7'd0, cmd.text};
                    3'd3:    sel_byte = {7'd0, cmd.info};
                    3'd4:    sel_byte = {7'd0, cmd.keep};
                    default: sel_byte = cmd.d2;
                endcase
            end
            sfb_pkg::KIND_READING:
            begin
                last_step = 3'd1;
                sel_byte  = (step == 3'd0) ? cmd.d0 : cmd.d1;
            end
            default:
            begin
                // dropped byte: skip straight to the checksum
                step      = idx_reg + {2'd0, !cmd.emit};
                last_step = cmd.close ? 3'd2 : 3'd0;
                summed    = (step == 3'd0);
                case (step)
                    3'd0:    sel_byte = cmd.d0;
                    3'd1:    sel_byte = sum_reg[7:0];
                    default: sel_byte = sum_reg[15:8];
                endcase
                sel_last = (step == 3'd2);
            end
        endcase

        load    = !cmd_empty && (!out_valid_reg || !out_stall);
        cmd_pop = load && (step == last_step);

        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            byte_next      = sel_byte;
            last_next      = sel_last;
            idx_next       = cmd_pop ? 3'd0 : idx_reg + 1'b1;
            if (summed)
            begin
                if (cmd.kind == sfb_pkg::KIND_HEADER && step == 3'd0)
                    sum_next = {8'd0, sel_byte};
                else
                    sum_next = sum_reg + {8'd0, sel_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/sensor_frame_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_builder
// Radio frame builder: header, sensor readings, payload and 16-bit sum.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while the command queue (QUEUE_DEPTH
// entries) has room; out-of-order and overflow words are consumed with no
// output. The byte sequencer behind the queue emits one frame byte per cycle
// unless out_stall holds it: a begin word yields 6 bytes, a reading 2, a
// payload byte 1, the closing payload word 2 or 3 (checksum low, then high
// with frame_last). Sustained payload rate is one byte per cycle too; the
// queue absorbs header and reading bytes until full, then in_stall rises.
module sensor_frame_builder #(
    parameter int MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int QUEUE_DEPTH = sfb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  destination,
    input  logic [7:0]  sender,
    input  logic [7:0]  origin_node,
    input  logic        text_flag,
    input  logic        info_flag,
    input  logic        keepalive_flag,
    input  logic [15:0] reading,
    input  logic [7:0]  data_byte,
    input  logic        payload_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_last
);

    sfb_pkg::cmd_t front_cmd;
    sfb_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    logic          accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    sfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (operation),
        .destination    (destination),
        .sender         (sender),
        .origin_node    (origin_node),
        .text_flag      (text_flag),
        .info_flag      (info_flag),
        .keepalive_flag (keepalive_flag),
        .reading        (reading),
        .data_byte      (data_byte),
        .payload_last   (payload_last),
        .push           (push),
        .cmd            (front_cmd)
    );

    sfb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    sfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .cmd_empty  (q_empty),
        .cmd_pop    (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

// ===== rtl/sfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks for the sensor frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module sfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       frame_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte)
                                   && $stable(frame_last))
        else $error("output word changed under stall");

    // a full queue means the sequencer has a word out
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with output idle");

    // a frame-ending byte is never followed directly by another one
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_last |=> !(out_valid && frame_last))
        else $error("two frame ends back to back");

endmodule

bind sensor_frame_builder sfb_checker u_sfb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
);
